// File: rtl/lpr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the line pixel rasterizer.
// Used by every module of the block and by the channel interfaces.
package lpr_pkg;

    localparam int CoordBits  = 9;
    localparam int ErrBits    = CoordBits + 4;
    localparam int IncBits    = CoordBits + 3;
    localparam int SumBits    = CoordBits + 5;
    localparam int QueueDepth = 2;
    localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCntBits = $clog2(QueueDepth + 1);

    typedef logic [CoordBits-1:0]      t_coord;
    typedef logic signed [ErrBits-1:0] t_err;
    typedef logic signed [IncBits-1:0] t_inc;
    typedef logic signed [SumBits-1:0] t_sum;
    typedef logic [QueuePtrBits-1:0]   t_qptr;
    typedef logic [QueueCntBits-1:0]   t_qcnt;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    // Saturation limits of the midpoint error, held at the width of the update sum.
    localparam t_sum SumErrMax = t_sum'((64'sd1 <<< (ErrBits - 1)) - 64'sd1);
    localparam t_sum SumErrMin = -SumErrMax - t_sum'(1);

    // One classified item, as handed from the front to the back.
    typedef struct packed {
        t_op    op;
        logic   swapped;
        t_coord major_pos;
        t_coord minor_pos;
        t_coord major_stop;
        t_err   init_err;
        t_inc   inc_e;
        t_inc   inc_ne;
    } t_cmd;

    function automatic t_err sat_err(input t_sum v);
        t_err r;
        if (v > SumErrMax) begin
            r = t_err'(SumErrMax);
        end else if (v < SumErrMin) begin
            r = t_err'(SumErrMin);
        end else begin
            r = t_err'(v);
        end
        return r;
    endfunction

endpackage

// File: rtl/lpr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the line pixel rasterizer: command input
// and pixel output. Depends on lpr_pkg for the coordinate type.
interface lpr_cmd_if import lpr_pkg::*;;
    logic   valid;
    logic   ready;
    logic   operation;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;

    modport source (output valid, output operation, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink   (input valid, input operation, input x_start, input y_start,
                    input x_end, input y_end, output ready);
endinterface

interface lpr_pix_if import lpr_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface

// File: rtl/lpr_front.sv
`timescale 1ns / 1ps
// Front end: accepts command items, orders endpoints, picks the major axis and
// precomputes the error terms. Depends on lpr_pkg and lpr_cmd_if.
module lpr_front import lpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpr_cmd_if.sink   i_cmd,
    output logic      o_push_valid,
    output t_cmd      o_push_cmd,
    input  logic      i_push_ready
);

    logic                   r_valid;
    logic                   n_valid;
    t_cmd                   r_cmd;
    t_cmd                   n_cmd;
    logic                   accept;
    logic                   swap_ends;
    t_coord                 xa;
    t_coord                 ya;
    t_coord                 xb;
    t_coord                 yb;
    t_coord                 dx;
    logic signed [CoordBits:0] dy;
    logic                   steep;
    t_coord                 dmaj;
    logic signed [CoordBits:0] dmin;

    assign i_cmd.ready  = !r_valid || i_push_ready;
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_comb begin
        // Endpoints go in order of x, and of y when x is equal.
        swap_ends = (i_cmd.x_start > i_cmd.x_end) ||
                    ((i_cmd.x_start == i_cmd.x_end) && (i_cmd.y_start > i_cmd.y_end));
        xa = swap_ends ? i_cmd.x_end   : i_cmd.x_start;
        ya = swap_ends ? i_cmd.y_end   : i_cmd.y_start;
        xb = swap_ends ? i_cmd.x_start : i_cmd.x_end;
        yb = swap_ends ? i_cmd.y_start : i_cmd.y_end;

        dx    = xb - xa;
        dy    = $signed({1'b0, yb}) - $signed({1'b0, ya});
        steep = dy > $signed({1'b0, dx});
        dmaj  = steep ? dy[CoordBits-1:0] : dx;
        dmin  = steep ? $signed({1'b0, dx}) : dy;

        n_cmd.op         = t_op'(i_cmd.operation);
        n_cmd.swapped    = steep;
        n_cmd.major_pos  = steep ? ya : xa;
        n_cmd.minor_pos  = steep ? xa : ya;
        n_cmd.major_stop = steep ? yb : xb;
        n_cmd.init_err   = (t_err'(dmin) <<< 1) - t_err'({1'b0, dmaj});
        n_cmd.inc_e      = t_inc'(dmin) <<< 1;
        n_cmd.inc_ne     = (t_inc'(dmin) - t_inc'({1'b0, dmaj})) <<< 1;

        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/lpr_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and the back end.
// Depends on lpr_pkg for the item type and the depth.
module lpr_queue import lpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    t_cmd  r_mem [QueueDepth];
    t_qptr r_wr_ptr;
    t_qptr n_wr_ptr;
    t_qptr r_rd_ptr;
    t_qptr n_rd_ptr;
    t_qcnt r_count;
    t_qcnt n_count;
    logic  push;
    logic  pop;

    assign o_push_ready = (r_count != t_qcnt'(QueueDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == t_qptr'(QueueDepth - 1)) ? '0 : r_wr_ptr + t_qptr'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == t_qptr'(QueueDepth - 1)) ? '0 : r_rd_ptr + t_qptr'(1);
        end
        if (push && !pop) begin
            n_count = r_count + t_qcnt'(1);
        end else if (pop && !push) begin
            n_count = r_count - t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/lpr_back.sv
`timescale 1ns / 1ps
// Back end: holds the active line, steps it one pixel per advance item and
// drives the registered pixel output. Depends on lpr_pkg and lpr_pix_if.
module lpr_back import lpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    lpr_pix_if.source  o_pix
);

    logic   r_busy;
    logic   n_busy;
    t_coord r_major;
    t_coord n_major;
    t_coord r_minor;
    t_coord n_minor;
    t_coord r_stop;
    t_coord n_stop;
    logic   r_swapped;
    logic   n_swapped;
    t_err   r_err;
    t_err   n_err;
    t_inc   r_inc_e;
    t_inc   n_inc_e;
    t_inc   r_inc_ne;
    t_inc   n_inc_ne;
    logic   r_o_valid;
    logic   n_o_valid;
    t_coord r_o_x;
    t_coord n_o_x;
    t_coord r_o_y;
    t_coord n_o_y;
    logic   r_o_last;
    logic   n_o_last;
    logic   slot_free;
    logic   is_start;
    logic   do_pixel;
    logic   at_stop;
    logic   step_minor;

    assign o_pix.valid      = r_o_valid;
    assign o_pix.pixel_x    = r_o_x;
    assign o_pix.pixel_y    = r_o_y;
    assign o_pix.last_pixel = r_o_last;

    always_comb begin
        slot_free  = !r_o_valid || o_pix.ready;
        is_start   = (i_cmd.op == OP_START);
        // An advance with no line active is dropped without waiting for the output.
        o_pop      = i_valid && (is_start || !r_busy || slot_free);
        do_pixel   = i_valid && !is_start && r_busy && slot_free;
        at_stop    = (r_major == r_stop);
        step_minor = (r_err > t_err'(0));

        n_busy    = r_busy;
        n_major   = r_major;
        n_minor   = r_minor;
        n_stop    = r_stop;
        n_swapped = r_swapped;
        n_err     = r_err;
        n_inc_e   = r_inc_e;
        n_inc_ne  = r_inc_ne;
        n_o_valid = r_o_valid && !o_pix.ready;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_o_last  = r_o_last;

        if (i_valid && is_start) begin
            n_busy    = 1'b1;
            n_major   = i_cmd.major_pos;
            n_minor   = i_cmd.minor_pos;
            n_stop    = i_cmd.major_stop;
            n_swapped = i_cmd.swapped;
            n_err     = i_cmd.init_err;
            n_inc_e   = i_cmd.inc_e;
            n_inc_ne  = i_cmd.inc_ne;
        end else if (do_pixel) begin
            n_o_valid = 1'b1;
            n_o_x     = r_swapped ? r_minor : r_major;
            n_o_y     = r_swapped ? r_major : r_minor;
            n_o_last  = at_stop;
            if (at_stop) begin
                n_busy = 1'b0;
            end else begin
                n_major = r_major + t_coord'(1);
                if (step_minor) begin
                    n_minor = r_minor + t_coord'(1);
                    n_err   = sat_err(t_sum'(r_err) + t_sum'(r_inc_ne));
                end else begin
                    n_err   = sat_err(t_sum'(r_err) + t_sum'(r_inc_e));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major   <= n_major;
        r_minor   <= n_minor;
        r_stop    <= n_stop;
        r_swapped <= n_swapped;
        r_err     <= n_err;
        r_inc_e   <= n_inc_e;
        r_inc_ne  <= n_inc_ne;
        r_o_x     <= n_o_x;
        r_o_y     <= n_o_y;
        r_o_last  <= n_o_last;
    end

endmodule

// File: rtl/line_pixel_rasterizer.sv
`timescale 1ns / 1ps
// Midpoint line rasterizer: a start item sets up a line between two endpoints,
// and each later advance item returns one pixel of it, the final one flagged as
// last; advances with no line active return nothing. Items are accepted one per
// clock while the front is not held by a full queue, and the block returns one
// pixel per clock while advance items arrive and the output is taken, the rate
// being set by the error update in the back end. The pixel of an advance item
// passes the front register, a queue entry and the output register before it
// is offered. Lines with a negative slope come out as a flat run along x.
// Depends on lpr_pkg, lpr_ifs, lpr_front, lpr_queue and lpr_back.
module line_pixel_rasterizer import lpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpr_cmd_if.sink    i_cmd,
    lpr_pix_if.source  o_pix
);

    logic push_valid;
    t_cmd push_cmd;
    logic push_ready;
    logic pop_valid;
    t_cmd pop_cmd;
    logic pop;

    lpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    lpr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    lpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule

// File: rtl/lpr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line pixel rasterizer, bound to the top level.
// Depends on lpr_pkg for the coordinate type.
module lpr_checker import lpr_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_cmd_ready,
    input logic   i_pix_valid,
    input logic   i_pix_ready,
    input t_coord i_pix_x,
    input t_coord i_pix_y,
    input logic   i_pix_last
);

    // After reset the front end is empty and must take an item at once.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_cmd_ready)
        else $error("command channel not ready after reset");

    // No pixel can reach the output just after reset, before an item has passed the front register and the queue.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid ##1 !i_pix_valid)
        else $error("pixel output valid too soon after reset");

    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=>
            i_pix_valid && $stable(i_pix_x) && $stable(i_pix_y) && $stable(i_pix_last))
        else $error("stalled pixel changed or dropped");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_x     (o_pix.pixel_x),
    .i_pix_y     (o_pix.pixel_y),
    .i_pix_last  (o_pix.last_pixel)
);
